// ----- src/cpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle point generator package
// Shared constants and the queue status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

  localparam int unsigned GROUP_POINTS = 8;
  localparam int unsigned IDX_BITS     = $clog2(GROUP_POINTS);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- src/cpg_in_if.sv -----
// ----------------------------------------------------------------------------
// Circle request channel
// Valid/ready channel that carries one start or continue request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpg_in_if #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, start_req, center_x, center_y, radius, input ready);
  modport sink   (input valid, start_req, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// ----- src/cpg_out_if.sv -----
// ----------------------------------------------------------------------------
// Circle point channel
// Valid/ready channel that carries one rasterized point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cpg_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  point_x;
  logic signed [COORD_BITS:0]  point_y;
  logic                        last_of_group;
  logic                        circle_done;

  modport source (output valid, point_x, point_y, last_of_group, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, last_of_group, circle_done, output ready);
endinterface

`default_nettype wire

// ----- src/cpg_fifo.sv -----
// ----------------------------------------------------------------------------
// Group queue
// Two-entry queue of iteration records between the stepper and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_fifo #(
  parameter int unsigned WIDTH = 47
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output cpg_pkg::q_status_t    status_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wptr_d  = push_i ? ~wptr_q : wptr_q;
    rptr_d  = pop_i ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o         = mem_q[rptr_q];
  assign status_o.full   = (count_q == 2'd2);
  assign status_o.empty  = (count_q == 2'd0);

endmodule

`default_nettype wire

// ----- src/cpg_front.sv -----
// ----------------------------------------------------------------------------
// Circle stepper
// Accepts requests, holds the circle state and runs one midpoint iteration
// per request, queueing the iteration record for the emitter when it steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_front #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10,
  localparam int unsigned STEP_BITS  = RADIUS_BITS + 1,
  localparam int unsigned DEC_BITS   = RADIUS_BITS + 6,
  localparam int unsigned REC_BITS   = 2 * COORD_BITS + 2 * STEP_BITS + 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  cpg_in_if.sink                   in_i,
  input  cpg_pkg::q_status_t       q_status_i,
  output logic                     push_o,
  output logic     [REC_BITS-1:0]  rec_o
);

  logic signed [COORD_BITS-1:0] cx_q, cx_d;
  logic signed [COORD_BITS-1:0] cy_q, cy_d;
  logic        [STEP_BITS-1:0]  x_q, x_d;
  logic        [STEP_BITS-1:0]  y_q, y_d;
  logic signed [DEC_BITS-1:0]   d_q, d_d;

  logic                         accept;
  logic                         step;
  logic        [STEP_BITS-1:0]  x_eff, y_eff, y_next, x_next;
  logic signed [DEC_BITS-1:0]   d_eff, d_next, x_ext, y_ext;
  logic                         done;

  assign in_i.ready = ~q_status_i.full;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    if (in_i.start_req) begin
      x_eff = '0;
      y_eff = STEP_BITS'(in_i.radius);
      d_eff = DEC_BITS'(3) - (DEC_BITS'(in_i.radius) <<< 1);
      cx_d  = in_i.center_x;
      cy_d  = in_i.center_y;
    end else begin
      x_eff = x_q;
      y_eff = y_q;
      d_eff = d_q;
      cx_d  = cx_q;
      cy_d  = cy_q;
    end
    step  = (x_eff < y_eff);
    x_ext = DEC_BITS'(x_eff);
    y_ext = DEC_BITS'(y_eff);
    if (!d_eff[DEC_BITS-1]) begin
      d_next = d_eff + ((x_ext - y_ext) <<< 2) + DEC_BITS'(10);
      y_next = y_eff - STEP_BITS'(1);
    end else begin
      d_next = d_eff + (x_ext <<< 2) + DEC_BITS'(6);
      y_next = y_eff;
    end
    x_next = x_eff + STEP_BITS'(1);
    done   = ~(x_next < y_next);
    if (step) begin
      x_d = x_next;
      y_d = y_next;
      d_d = d_next;
    end else begin
      x_d = x_eff;
      y_d = y_eff;
      d_d = d_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      x_q  <= '0;
      y_q  <= '0;
      d_q  <= '0;
    end else if (accept) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      x_q  <= x_d;
      y_q  <= y_d;
      d_q  <= d_d;
    end
  end

  assign push_o = accept & step;
  assign rec_o  = {done, y_eff, x_eff, cy_d, cx_d};

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("Group record pushed into a full queue.");

endmodule

`default_nettype wire

// ----- src/cpg_back.sv -----
// ----------------------------------------------------------------------------
// Point emitter
// Takes iteration records from the queue and sends their eight symmetric
// points, one per cycle while the point channel is ready, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_back #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10,
  localparam int unsigned STEP_BITS  = RADIUS_BITS + 1,
  localparam int unsigned REC_BITS   = 2 * COORD_BITS + 2 * STEP_BITS + 1,
  localparam int unsigned PT_BITS    = COORD_BITS + RADIUS_BITS + 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [REC_BITS-1:0] rec_i,
  input  cpg_pkg::q_status_t       q_status_i,
  output logic                     pop_o,
  cpg_out_if.source                out_o
);

  logic signed [COORD_BITS-1:0]        cx_q, cy_q;
  logic        [STEP_BITS-1:0]         x_q, y_q;
  logic                                done_q;
  logic                                active_q;
  logic        [cpg_pkg::IDX_BITS-1:0] idx_q;

  logic                                ov_q;
  logic signed [COORD_BITS:0]          px_q, py_q;
  logic                                last_q, cdone_q;

  logic                                emit;
  logic                                last_idx;
  logic        [STEP_BITS-1:0]         a_val, b_val;
  logic signed [PT_BITS-1:0]           cx_ext, cy_ext, a_ext, b_ext, sum_x, sum_y;

  assign last_idx = (idx_q == cpg_pkg::IDX_BITS'(cpg_pkg::GROUP_POINTS - 1));
  assign emit     = active_q & (~ov_q | out_o.ready);
  assign pop_o    = ~q_status_i.empty & (~active_q | (emit & last_idx));

  always_comb begin
    a_val  = idx_q[2] ? y_q : x_q;
    b_val  = idx_q[2] ? x_q : y_q;
    cx_ext = PT_BITS'(cx_q);
    cy_ext = PT_BITS'(cy_q);
    a_ext  = PT_BITS'(a_val);
    b_ext  = PT_BITS'(b_val);
    sum_x  = idx_q[1] ? (cx_ext - a_ext) : (cx_ext + a_ext);
    sum_y  = idx_q[0] ? (cy_ext - b_ext) : (cy_ext + b_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (emit) begin
        if (last_idx) begin
          active_q <= 1'b0;
          idx_q    <= '0;
        end else begin
          idx_q <= idx_q + cpg_pkg::IDX_BITS'(1);
        end
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {done_q, y_q, x_q, cy_q, cx_q} <= rec_i;
    end
    if (emit) begin
      px_q    <= sum_x[COORD_BITS:0];
      py_q    <= sum_y[COORD_BITS:0];
      last_q  <= last_idx;
      cdone_q <= last_idx & done_q;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.point_x       = px_q;
  assign out_o.point_y       = py_q;
  assign out_o.last_of_group = last_q;
  assign out_o.circle_done   = cdone_q;

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_status_i.empty)
    else $error("Group record popped from an empty queue.");

  a_idle_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (idx_q == '0))
    else $error("Point index is nonzero while no group is active.");

  a_done_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.circle_done) |-> out_o.last_of_group)
    else $error("Done mark on a point that does not close its group.");

endmodule

`default_nettype wire

// ----- src/circle_point_generator.sv -----
// ----------------------------------------------------------------------------
// Circle point generator
// Midpoint circle rasterizer: each request runs one iteration and, if it
// steps, yields the eight symmetric points of that iteration.
// ----------------------------------------------------------------------------
// Channel | Dir | Request carries                              | Per request
// in_i    | in  | start_req, center_x, center_y, radius        | one iteration
// out_o   | out | point_x, point_y, last_of_group, circle_done | 0 or 8 points
//
// A request is stepped in the cycle it is taken; its eight points then leave
// the emitter one per cycle while the point channel is ready.
// A two-entry group queue lets the stepper take requests while points drain.
// Reset clears the held center, the loop variables and the decision value.
// A stalled point channel stalls the emitter, then fills the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circle_point_generator #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpg_in_if.sink    in_i,
  cpg_out_if.source out_o
);

  localparam int unsigned REC_BITS = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 1;

  logic                  push;
  logic                  pop;
  logic [REC_BITS-1:0]   wrec;
  logic [REC_BITS-1:0]   rrec;
  cpg_pkg::q_status_t    q_status;

  cpg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .rec_o      (wrec)
  );

  cpg_fifo #(
    .WIDTH (REC_BITS)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wrec),
    .pop_i    (pop),
    .rdata_o  (rrec),
    .status_o (q_status)
  );

  cpg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rrec),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
